FILE: rtl/ftr_pkg.sv
// Shared types and constants for the flat triangle rasterizer.
// Used by the input queue, the fill sequencer and the top level.
package ftr_pkg;

    localparam logic [7:0] ALPHA = 8'hFF;

    typedef struct packed {
        logic       action;
        logic [8:0] vx_a;
        logic [8:0] vy_a;
        logic [8:0] vx_b;
        logic [8:0] vy_b;
        logic [8:0] vx_c;
        logic [8:0] vy_c;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qout;

endpackage

FILE: rtl/ftr_front.sv
// Front end of the rasterizer: accepts items and holds them in a two-entry queue.
// Depends on ftr_pkg for the item type.
module ftr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ftr_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_busy,
    output ftr_pkg::t_qout o_q
);

    ftr_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign o_busy  = (r_cnt == 2'd2);
    assign push    = i_start && !o_busy;
    assign pop     = i_pop && (r_cnt != 2'd0);
    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: rtl/ftr_div.sv
// Iterative divider giving floor((2n + d) / (2d)) for a signed n and positive d.
// One quotient bit per cycle; standalone, no package use.
module ftr_div #(
    parameter int NW = 46,
    parameter int DW = 29
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic        [DW-1:0] i_den,
    output logic                 o_done,
    output logic signed [NW-1:0] o_quot
);

    localparam int MW = NW + 1;
    localparam int CW = $clog2(MW + 1);

    logic signed [MW-1:0] n2;
    logic        [MW-1:0] mag;
    logic                 r_busy;
    logic        [CW-1:0] r_cnt;
    logic        [MW-1:0] r_mag;
    logic        [DW:0]   r_den2;
    logic        [DW+1:0] r_rem;
    logic        [MW-1:0] r_q;
    logic                 r_neg;
    logic                 r_done;
    logic signed [NW-1:0] r_quot;
    logic        [DW+1:0] rem_sh;
    logic                 ge;
    logic        [DW+1:0] rem_nx;
    logic        [MW-1:0] q_nx;
    logic        [MW-1:0] fq;

    assign n2  = (MW'(i_num) <<< 1) + MW'($signed({1'b0, i_den}));
    assign mag = (n2 < 0) ? MW'(-n2) : MW'(n2);

    assign rem_sh = {r_rem[DW:0], r_mag[MW-1]};
    assign ge     = (rem_sh >= {1'b0, r_den2});
    assign rem_nx = ge ? (rem_sh - {1'b0, r_den2}) : rem_sh;
    assign q_nx   = {r_q[MW-2:0], ge};
    assign fq     = r_neg ? (~(q_nx + MW'(rem_nx != '0)) + MW'(1)) : q_nx;

    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag  <= mag;
            r_den2 <= {i_den, 1'b0};
            r_rem  <= '0;
            r_q    <= '0;
            r_neg  <= (n2 < 0);
        end else if (r_busy) begin
            r_mag <= {r_mag[MW-2:0], 1'b0};
            r_rem <= rem_nx;
            r_q   <= q_nx;
            if (r_cnt == CW'(1)) begin
                r_quot <= NW'(fq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/ftr_back.sv
// Back end of the rasterizer: sorts, splits, steps edges and spans, emits pixels.
// Depends on ftr_pkg and the shared divider ftr_div.
module ftr_back #(
    parameter int CANVAS_WIDTH  = 512,
    parameter int CANVAS_HEIGHT = 512,
    parameter int FRAC_BITS     = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ftr_pkg::t_qout i_q,
    output logic           o_pop,
    output logic           o_strobe,
    output logic           o_pixel_valid,
    output logic [8:0]     o_pixel_x,
    output logic [8:0]     o_pixel_y,
    output logic [31:0]    o_pixel_argb,
    output logic           o_last_pixel
);

    localparam int PW = FRAC_BITS + 12;
    localparam int NW = PW + FRAC_BITS + 2;
    localparam int DW = PW + 1;
    localparam logic signed [PW:0] HALF = (PW + 1)'(1) <<< (FRAC_BITS - 1);
    localparam logic [DW-1:0] ONE_M1 = (DW'(1) << FRAC_BITS) - DW'(1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SPLIT  = 4'd1;
    localparam logic [3:0] S_PART   = 4'd2;
    localparam logic [3:0] S_SPAN   = 4'd3;
    localparam logic [3:0] S_SEEK   = 4'd4;
    localparam logic [3:0] S_DSTART = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;

    localparam logic [2:0] T_E0  = 3'd0;
    localparam logic [2:0] T_E1  = 3'd1;
    localparam logic [2:0] T_E2  = 3'd2;
    localparam logic [2:0] T_E3  = 3'd3;
    localparam logic [2:0] T_S0  = 3'd4;
    localparam logic [2:0] T_S1  = 3'd5;
    localparam logic [2:0] T_SPL = 3'd6;

    function automatic logic [8:0] to_pix(input logic signed [PW-1:0] p, input int limit);
        logic signed [PW:0] v;
        logic signed [PW:0] r;
        v = (PW + 1)'(p) + HALF;
        r = v >>> FRAC_BITS;
        if (v < 0) begin
            return 9'd0;
        end else if (r > (limit - 1)) begin
            return 9'(limit - 1);
        end else begin
            return 9'(r);
        end
    endfunction

    function automatic logic [9:0] abs10(input logic signed [9:0] v);
        return (v < 0) ? 10'(-v) : 10'(v);
    endfunction

    logic [3:0]           r_state;
    logic [3:0]           n_state;
    logic [8:0]           r_vx [3];
    logic [8:0]           r_vy [3];
    logic [8:0]           r_spx;
    logic [23:0]          r_col;
    logic [1:0]           r_part;
    logic signed [PW-1:0] r_ep [4];
    logic signed [PW-1:0] r_ei [4];
    logic [10:0]          r_ec0;
    logic [10:0]          r_ec1;
    logic signed [PW-1:0] r_sp [2];
    logic signed [PW-1:0] r_si [2];
    logic [10:0]          r_sc0;
    logic [10:0]          r_sc1;
    logic signed [20:0]   r_prod;
    logic [10:0]          r_steps;
    logic [DW-1:0]        r_len;
    logic signed [PW:0]   r_sdx;
    logic signed [PW:0]   r_sdy;
    logic [2:0]           r_tgt;
    logic                 r_pend;
    logic                 r_stb;
    logic                 r_oval;
    logic [8:0]           r_ox;
    logic [8:0]           r_oy;
    logic [31:0]          r_oargb;
    logic                 r_olast;

    logic [8:0]  sx [3];
    logic [8:0]  sy [3];
    logic [8:0]  tx;
    logic [8:0]  ty;
    logic [8:0]  pax, pay, pbx, pby, pcx, pcy;
    logic signed [9:0] d_bx, d_by, d_cx, d_cy;
    logic [9:0]  m1, m2, steps;
    logic [8:0]  dy_l;
    logic [8:0]  t_l;
    logic signed [PW:0] sdx, sdy;
    logic [DW-1:0] adx, ady, len;
    logic        seek_more;
    logic        div_start;
    logic        div_done;
    logic signed [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic signed [NW-1:0] div_quot;

    // Three compare-and-swap stages on y, swapping only on strictly greater.
    always_comb begin
        tx = '0;
        ty = '0;
        sx[0] = i_q.item.vx_a; sy[0] = i_q.item.vy_a;
        sx[1] = i_q.item.vx_b; sy[1] = i_q.item.vy_b;
        sx[2] = i_q.item.vx_c; sy[2] = i_q.item.vy_c;
        if (sy[0] > sy[1]) begin
            tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
        end
        if (sy[1] > sy[2]) begin
            tx = sx[1]; ty = sy[1]; sx[1] = sx[2]; sy[1] = sy[2]; sx[2] = tx; sy[2] = ty;
        end
        if (sy[0] > sy[1]) begin
            tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
        end
    end

    assign pax = (r_part == 2'd1) ? r_vx[0] : r_spx;
    assign pay = (r_part == 2'd1) ? r_vy[0] : r_vy[1];
    assign pbx = r_vx[1];
    assign pby = r_vy[1];
    assign pcx = (r_part == 2'd1) ? r_spx : r_vx[2];
    assign pcy = (r_part == 2'd1) ? r_vy[1] : r_vy[2];

    assign d_bx = $signed({1'b0, pbx}) - $signed({1'b0, pax});
    assign d_by = $signed({1'b0, pby}) - $signed({1'b0, pay});
    assign d_cx = $signed({1'b0, pcx}) - $signed({1'b0, pax});
    assign d_cy = $signed({1'b0, pcy}) - $signed({1'b0, pay});
    assign m1 = (abs10(d_bx) > abs10(d_by)) ? abs10(d_bx) : abs10(d_by);
    assign m2 = (abs10(d_cx) > abs10(d_cy)) ? abs10(d_cx) : abs10(d_cy);
    assign steps = (m1 > m2) ? m1 : m2;

    assign dy_l = r_vy[2] - r_vy[0];
    assign t_l  = r_vy[1] - r_vy[0];

    assign sdx = (PW + 1)'(r_ep[2]) - (PW + 1)'(r_ep[0]);
    assign sdy = (PW + 1)'(r_ep[3]) - (PW + 1)'(r_ep[1]);
    assign adx = (sdx < 0) ? DW'(-sdx) : DW'(sdx);
    assign ady = (sdy < 0) ? DW'(-sdy) : DW'(sdy);
    assign len = (adx > ady) ? adx : ady;

    assign seek_more = (r_part != 2'd0) && (r_sc0 >= r_sc1);
    assign div_start = (r_state == S_DSTART);
    assign o_pop     = (r_state == S_IDLE) && i_q.valid;

    always_comb begin
        case (r_tgt)
            T_E0: begin
                div_num = NW'(d_bx) <<< FRAC_BITS;
                div_den = DW'(r_steps);
            end
            T_E1: begin
                div_num = NW'(d_by) <<< FRAC_BITS;
                div_den = DW'(r_steps);
            end
            T_E2: begin
                div_num = NW'(d_cx) <<< FRAC_BITS;
                div_den = DW'(r_steps);
            end
            T_E3: begin
                div_num = NW'(d_cy) <<< FRAC_BITS;
                div_den = DW'(r_steps);
            end
            T_S0: begin
                div_num = NW'(r_sdx) <<< FRAC_BITS;
                div_den = r_len;
            end
            T_S1: begin
                div_num = NW'(r_sdy) <<< FRAC_BITS;
                div_den = r_len;
            end
            default: begin
                div_num = NW'(r_prod);
                div_den = DW'(dy_l);
            end
        endcase
    end

    ftr_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q.valid) begin
                    if (!i_q.item.action) begin
                        n_state = S_SPLIT;
                    end else if (r_part != 2'd0) begin
                        n_state = S_SEEK;
                    end
                end
            end
            S_SPLIT: begin
                n_state = (dy_l == 9'd0) ? S_PART : S_DSTART;
            end
            S_PART: begin
                n_state = (steps == 10'd0) ? S_SEEK : S_DSTART;
            end
            S_SPAN: begin
                n_state = (len == '0) ? S_SEEK : S_DSTART;
            end
            S_SEEK: begin
                if (!seek_more) begin
                    n_state = S_IDLE;
                end else if (r_ec0 < r_ec1) begin
                    n_state = S_SPAN;
                end else if (r_part == 2'd1) begin
                    n_state = S_PART;
                end
            end
            S_DSTART: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    case (r_tgt)
                        T_E3:    n_state = S_SPAN;
                        T_S1:    n_state = S_SEEK;
                        T_SPL:   n_state = S_PART;
                        default: n_state = S_DSTART;
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_q.valid && !i_q.item.action) begin
                    for (int k = 0; k < 3; k++) begin
                        r_vx[k] <= sx[k];
                        r_vy[k] <= sy[k];
                    end
                    r_col <= {i_q.item.red, i_q.item.green, i_q.item.blue};
                end else if (i_q.valid) begin
                    r_oval <= (r_part != 2'd0);
                    r_olast <= (r_part == 2'd0);
                    if (r_part == 2'd0) begin
                        r_ox    <= 9'd0;
                        r_oy    <= 9'd0;
                        r_oargb <= 32'd0;
                    end else begin
                        r_ox    <= to_pix(r_sp[0], CANVAS_WIDTH);
                        r_oy    <= to_pix(r_sp[1], CANVAS_HEIGHT);
                        r_oargb <= {ftr_pkg::ALPHA, r_col};
                        r_sc0   <= r_sc0 + 11'd1;
                        r_sp[0] <= r_sp[0] + r_si[0];
                        r_sp[1] <= r_sp[1] + r_si[1];
                    end
                end
            end
            S_SPLIT: begin
                r_prod <= $signed({12'd0, r_vx[0]}) * $signed({12'd0, dy_l})
                        + $signed({11'd0, t_l}) * ($signed({12'd0, r_vx[2]})
                        - $signed({12'd0, r_vx[0]}));
                r_tgt <= T_SPL;
                if (dy_l == 9'd0) begin
                    r_spx <= r_vx[1];
                end
            end
            S_PART: begin
                r_ec0 <= 11'd0;
                r_sc0 <= 11'd0;
                r_sc1 <= 11'd0;
                r_ec1 <= 11'(steps);
                r_steps <= 11'(steps);
                r_tgt <= T_E0;
                if (steps == 10'd0) begin
                    for (int k = 0; k < 4; k++) begin
                        r_ei[k] <= '0;
                    end
                end else begin
                    r_ep[0] <= $signed(PW'(pax) << FRAC_BITS);
                    r_ep[1] <= $signed(PW'(pay) << FRAC_BITS);
                    r_ep[2] <= $signed(PW'(pax) << FRAC_BITS);
                    r_ep[3] <= $signed(PW'(pay) << FRAC_BITS);
                end
            end
            S_SPAN: begin
                r_sp[0] <= r_ep[0];
                r_sp[1] <= r_ep[1];
                r_sc0   <= 11'd0;
                r_len   <= len;
                r_sdx   <= sdx;
                r_sdy   <= sdy;
                r_tgt   <= T_S0;
                if (len == '0) begin
                    r_sc1   <= 11'd0;
                    r_si[0] <= '0;
                    r_si[1] <= '0;
                end else begin
                    r_sc1 <= 11'((len + ONE_M1) >> FRAC_BITS);
                end
            end
            S_SEEK: begin
                if (seek_more && (r_ec0 < r_ec1)) begin
                    r_ec0 <= r_ec0 + 11'd1;
                    for (int k = 0; k < 4; k++) begin
                        r_ep[k] <= r_ep[k] + r_ei[k];
                    end
                end
                if (!seek_more) begin
                    r_olast <= (r_part == 2'd0);
                end
            end
            S_DIV: begin
                if (div_done) begin
                    r_tgt <= r_tgt + 3'd1;
                    case (r_tgt)
                        T_E0, T_E1, T_E2, T_E3: r_ei[r_tgt[1:0]] <= PW'(div_quot);
                        T_S0:    r_si[0] <= PW'(div_quot);
                        T_S1:    r_si[1] <= PW'(div_quot);
                        default: r_spx   <= 9'(div_quot);
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_part  <= 2'd0;
            r_pend  <= 1'b0;
            r_stb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stb   <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q.valid && !i_q.item.action) begin
                        r_pend <= 1'b0;
                    end else if (i_q.valid) begin
                        if (r_part == 2'd0) begin
                            r_stb <= 1'b1;
                        end else begin
                            r_pend <= 1'b1;
                        end
                    end
                end
                S_SPLIT: begin
                    if (dy_l == 9'd0) begin
                        r_part <= 2'd1;
                    end
                end
                S_SEEK: begin
                    if (!seek_more) begin
                        r_stb  <= r_pend;
                        r_pend <= 1'b0;
                    end else if (r_ec0 >= r_ec1) begin
                        r_part <= (r_part == 2'd1) ? 2'd2 : 2'd0;
                    end
                end
                S_DIV: begin
                    if (div_done && (r_tgt == T_SPL)) begin
                        r_part <= 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_strobe      = r_stb;
    assign o_pixel_valid = r_oval;
    assign o_pixel_x     = r_ox;
    assign o_pixel_y     = r_oy;
    assign o_pixel_argb  = r_oargb;
    assign o_last_pixel  = r_olast;

endmodule

FILE: rtl/flat_triangle_rasterizer.sv
// Top level of the flat triangle rasterizer: input queue plus fill sequencer.
// Depends on ftr_pkg, ftr_front, ftr_back and ftr_div.
//
// An item is taken at a rising edge with start high and busy low. Action 0
// loads three vertices and a fill colour and returns nothing; action 1 asks
// for the next pixel and returns exactly one result, shown for one cycle with
// o_strobe high. The receiver cannot hold results off.
// Items wait in a two-entry queue; busy is high while that queue is full.
// A load runs one division for the split point (none when the long edge is
// flat), x and y divisions for both edges at each part setup with nonzero
// steps, and x and y span divisions for each new span row of nonzero length.
// With the sequencer idle, a request leaves the queue in S_IDLE, which
// registers the pixel; a pixel within a span is strobed from S_SEEK and an
// end marker straight from S_IDLE; a pixel that ends a span waits for the
// next row setup or the end of the fill. Every division runs through one
// shared divider that retires one quotient bit per cycle; the divider sets
// the throughput.
// Reset empties the queue and leaves no triangle loaded.
module flat_triangle_rasterizer #(
    parameter int CANVAS_WIDTH  = 512,
    parameter int CANVAS_HEIGHT = 512,
    parameter int FRAC_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [8:0]  i_vx_a,
    input  logic [8:0]  i_vy_a,
    input  logic [8:0]  i_vx_b,
    input  logic [8:0]  i_vy_b,
    input  logic [8:0]  i_vx_c,
    input  logic [8:0]  i_vy_c,
    input  logic [7:0]  i_fill_red,
    input  logic [7:0]  i_fill_green,
    input  logic [7:0]  i_fill_blue,
    output logic        o_strobe,
    output logic        o_pixel_valid,
    output logic [8:0]  o_pixel_x,
    output logic [8:0]  o_pixel_y,
    output logic [31:0] o_pixel_argb,
    output logic        o_last_pixel
);

    ftr_pkg::t_item item;
    ftr_pkg::t_qout q;
    logic           pop;

    assign item.action = i_action;
    assign item.vx_a   = i_vx_a;
    assign item.vy_a   = i_vy_a;
    assign item.vx_b   = i_vx_b;
    assign item.vy_b   = i_vy_b;
    assign item.vx_c   = i_vx_c;
    assign item.vy_c   = i_vy_c;
    assign item.red    = i_fill_red;
    assign item.green  = i_fill_green;
    assign item.blue   = i_fill_blue;

    ftr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (item),
        .i_pop   (pop),
        .o_busy  (busy),
        .o_q     (q)
    );

    ftr_back #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT),
        .FRAC_BITS     (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q           (q),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_pixel_valid (o_pixel_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_argb  (o_pixel_argb),
        .o_last_pixel  (o_last_pixel)
    );

`ifndef SYNTHESIS
    a_no_strobe_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe) else $error("result strobe right after reset");

    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_pixel_valid |-> o_last_pixel && (o_pixel_x == 9'd0)
        && (o_pixel_y == 9'd0) && (o_pixel_argb == 32'd0))
        else $error("malformed end marker");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_pixel_valid |-> (o_pixel_argb[31:24] == ftr_pkg::ALPHA))
        else $error("pixel without opaque alpha");
`endif

endmodule

FILE: sim/flat_triangle_rasterizer_tb.sv
// Self-checking testbench for the flat triangle rasterizer pixel stream.
// Depends on ftr_pkg and the flat_triangle_rasterizer top level; drives loads and pixel requests.
module flat_triangle_rasterizer_tb;

    localparam longint CW = 512;
    localparam longint CH = 512;
    localparam int FB = 16;
    localparam longint ONE = 64'sd1 << FB;
    localparam longint HALF = 64'sd1 << (FB - 1);
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef struct packed {
        logic        pvalid;
        logic [8:0]  px;
        logic [8:0]  py;
        logic [31:0] argb;
        logic        last;
    } t_pixel;

    typedef struct {
        ftr_pkg::t_item item;
        logic           chk;
        t_pixel         want;
    } t_row;

    logic i_clk, i_rst_n, start, busy;
    logic i_action;
    logic [8:0] i_vx_a, i_vy_a, i_vx_b, i_vy_b, i_vx_c, i_vy_c;
    logic [7:0] i_fill_red, i_fill_green, i_fill_blue;
    logic o_strobe, o_pixel_valid, o_last_pixel;
    logic [8:0] o_pixel_x, o_pixel_y;
    logic [31:0] o_pixel_argb;

    flat_triangle_rasterizer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_vx_a(i_vx_a), .i_vy_a(i_vy_a), .i_vx_b(i_vx_b),
        .i_vy_b(i_vy_b), .i_vx_c(i_vx_c), .i_vy_c(i_vy_c),
        .i_fill_red(i_fill_red), .i_fill_green(i_fill_green),
        .i_fill_blue(i_fill_blue), .o_strobe(o_strobe),
        .o_pixel_valid(o_pixel_valid), .o_pixel_x(o_pixel_x),
        .o_pixel_y(o_pixel_y), .o_pixel_argb(o_pixel_argb),
        .o_last_pixel(o_last_pixel)
    );

    longint vtx[3][2];
    longint splt[2];
    logic [23:0] colour;
    int unsigned part;
    longint epos[4], einc[4], erow, erows;
    longint spos[2], sinc[2], scnt, slen;

    t_pixel pending[$];
    int errors = 0;
    int pixels_seen = 0;
    int markers_seen = 0;
    int loads_sent = 0;

    function automatic longint absv(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint maxv(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function automatic longint div_round(longint n, longint d);
        longint nn, dd;
        nn = 2 * n + d;
        dd = 2 * d;
        if (nn >= 0) return nn / dd;
        return -((-nn + dd - 1) / dd);
    endfunction

    function automatic logic [8:0] round_pixel(longint p, longint lim);
        longint v;
        v = p + HALF;
        if (v < 0) return 9'd0;
        v = v >>> FB;
        if (v > lim - 1) v = lim - 1;
        return v[8:0];
    endfunction

    task automatic start_span();
        longint dx, dy, len;
        dx = epos[2] - epos[0];
        dy = epos[3] - epos[1];
        len = maxv(absv(dx), absv(dy));
        spos[0] = epos[0];
        spos[1] = epos[1];
        scnt = 0;
        if (len == 0) begin
            slen = 0;
            sinc[0] = 0;
            sinc[1] = 0;
        end else begin
            slen = (len + ONE - 1) / ONE;
            sinc[0] = div_round(dx * ONE, len);
            sinc[1] = div_round(dy * ONE, len);
        end
    endtask

    task automatic start_part(int unsigned p);
        longint a[2], b[2], c[2], steps;
        if (p == 1) begin
            a = vtx[0];
            c = splt;
        end else begin
            a = splt;
            c = vtx[2];
        end
        b = vtx[1];
        steps = maxv(maxv(absv(b[0] - a[0]), absv(b[1] - a[1])),
                     maxv(absv(c[0] - a[0]), absv(c[1] - a[1])));
        part = p;
        erow = 0;
        scnt = 0;
        slen = 0;
        if (steps == 0) begin
            erows = 0;
            for (int k = 0; k < 4; k++) einc[k] = 0;
        end else begin
            erows = steps;
            epos[0] = a[0] * ONE;
            epos[1] = a[1] * ONE;
            epos[2] = a[0] * ONE;
            epos[3] = a[1] * ONE;
            einc[0] = div_round((b[0] - a[0]) * ONE, steps);
            einc[1] = div_round((b[1] - a[1]) * ONE, steps);
            einc[2] = div_round((c[0] - a[0]) * ONE, steps);
            einc[3] = div_round((c[1] - a[1]) * ONE, steps);
            start_span();
        end
    endtask

    task automatic advance_fill();
        while (part != 0 && scnt >= slen) begin
            if (erow < erows) begin
                erow++;
                for (int k = 0; k < 4; k++) epos[k] += einc[k];
                start_span();
            end else if (part == 1) begin
                start_part(2);
            end else begin
                part = 0;
            end
        end
    endtask

    task automatic predict_pixel(input ftr_pkg::t_item it, output logic has,
                                 output t_pixel px);
        longint t0[2], dy, num;
        has = 0;
        px = '0;
        if (it.action == ACT_LOAD) begin
            vtx[0][0] = longint'(it.vx_a); vtx[0][1] = longint'(it.vy_a);
            vtx[1][0] = longint'(it.vx_b); vtx[1][1] = longint'(it.vy_b);
            vtx[2][0] = longint'(it.vx_c); vtx[2][1] = longint'(it.vy_c);
            if (vtx[0][1] > vtx[1][1]) begin t0 = vtx[0]; vtx[0] = vtx[1]; vtx[1] = t0; end
            if (vtx[1][1] > vtx[2][1]) begin t0 = vtx[1]; vtx[1] = vtx[2]; vtx[2] = t0; end
            if (vtx[0][1] > vtx[1][1]) begin t0 = vtx[0]; vtx[0] = vtx[1]; vtx[1] = t0; end
            dy = vtx[2][1] - vtx[0][1];
            if (dy == 0) begin
                splt[0] = vtx[1][0];
            end else begin
                num = vtx[0][0] * dy + (vtx[2][0] - vtx[0][0]) * (vtx[1][1] - vtx[0][1]);
                splt[0] = div_round(num, dy);
            end
            splt[1] = vtx[1][1];
            colour = {it.red, it.green, it.blue};
            start_part(1);
            advance_fill();
            return;
        end
        has = 1;
        if (part == 0) begin
            px = '{pvalid: 1'b0, px: 9'd0, py: 9'd0, argb: 32'd0, last: 1'b1};
            return;
        end
        px.pvalid = 1'b1;
        px.px = round_pixel(spos[0], CW);
        px.py = round_pixel(spos[1], CH);
        px.argb = {ftr_pkg::ALPHA, colour};
        scnt++;
        spos[0] += sinc[0];
        spos[1] += sinc[1];
        advance_fill();
        px.last = (part == 0);
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200000000;
        $display("flat_triangle_rasterizer test failed");
        $finish;
    end

    always @(posedge i_clk) begin
        t_pixel got, want;
        if (i_rst_n && o_strobe) begin
            got = '{o_pixel_valid, o_pixel_x, o_pixel_y, o_pixel_argb, o_last_pixel};
            if (got.pvalid) pixels_seen++; else markers_seen++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected v=%b x=%0d y=%0d argb=%h last=%b, got v=%b x=%0d y=%0d argb=%h last=%b",
                                 want.pvalid, want.px, want.py, want.argb, want.last,
                                 got.pvalid, got.px, got.py, got.argb, got.last);
                end
            end
        end
    end

    task automatic send_item(input ftr_pkg::t_item it);
        logic has;
        t_pixel px;
        start <= 1'b1;
        i_action <= it.action;
        i_vx_a <= it.vx_a; i_vy_a <= it.vy_a;
        i_vx_b <= it.vx_b; i_vy_b <= it.vy_b;
        i_vx_c <= it.vx_c; i_vy_c <= it.vy_c;
        i_fill_red <= it.red; i_fill_green <= it.green; i_fill_blue <= it.blue;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_pixel(it, has, px);
        if (has) pending = {pending, px};
        if (it.action == ACT_LOAD) loads_sent++;
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic ftr_pkg::t_item make_load(int maxspan);
        ftr_pkg::t_item it;
        int bx, by;
        it = '0;
        it.action = ACT_LOAD;
        bx = $urandom_range(0, 511);
        by = $urandom_range(0, 511);
        it.vx_a = 9'((bx + $urandom_range(0, maxspan)) % 512);
        it.vy_a = 9'((by + $urandom_range(0, maxspan)) % 512);
        it.vx_b = 9'((bx + $urandom_range(0, maxspan)) % 512);
        it.vy_b = 9'((by + $urandom_range(0, maxspan)) % 512);
        it.vx_c = 9'((bx + $urandom_range(0, maxspan)) % 512);
        it.vy_c = 9'((by + $urandom_range(0, maxspan)) % 512);
        it.red = 8'($urandom); it.green = 8'($urandom); it.blue = 8'($urandom);
        return it;
    endfunction

    function automatic ftr_pkg::t_item make_step();
        ftr_pkg::t_item it;
        it = ftr_pkg::t_item'({$urandom, $urandom, 19'($urandom)});
        it.action = ACT_STEP;
        return it;
    endfunction

    function automatic t_row lr(int xa, int ya, int xb, int yb, int xc, int yc, int r, int g, int b);
        t_row rw;
        rw.item = '{ACT_LOAD, 9'(xa), 9'(ya), 9'(xb), 9'(yb), 9'(xc), 9'(yc),
                    8'(r), 8'(g), 8'(b)};
        rw.chk = 0;
        rw.want = '0;
        return rw;
    endfunction

    function automatic t_row sr(logic chk, t_pixel w);
        t_row rw;
        rw.item = '0;
        rw.item.action = ACT_STEP;
        rw.chk = chk;
        rw.want = w;
        return rw;
    endfunction

    initial begin
        t_row dir[$];
        t_pixel marker;
        ftr_pkg::t_item it;
        int steps_left, guard;
        marker = '{1'b0, 9'd0, 9'd0, 32'd0, 1'b1};
        start = 0; i_action = 0;
        i_vx_a = 0; i_vy_a = 0; i_vx_b = 0; i_vy_b = 0; i_vx_c = 0; i_vy_c = 0;
        i_fill_red = 0; i_fill_green = 0; i_fill_blue = 0;
        i_rst_n = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Idle after reset, a single point, zero-size spans, the canvas corners, a flat triangle and general triangles.
        dir = {dir, sr(1, marker)};
        dir = {dir, lr(5, 7, 5, 7, 5, 7, 255, 0, 255)};
        dir = {dir, sr(1, marker)};
        dir = {dir, sr(0, '0)};
        dir = {dir, sr(0, '0)};
        dir = {dir, lr(511, 511, 511, 511, 511, 511, 0, 255, 0)};
        dir = {dir, sr(0, '0)};
        dir = {dir, sr(0, '0)};
        dir = {dir, lr(0, 0, 0, 0, 0, 0, 0, 0, 0)};
        dir = {dir, sr(0, '0)};
        dir = {dir, lr(0, 3, 4, 3, 2, 3, 1, 2, 3)};
        for (int k = 0; k < 6; k++) dir = {dir, sr(0, '0)};
        dir = {dir, lr(3, 0, 0, 4, 6, 2, 170, 85, 15)};
        for (int k = 0; k < 6; k++) dir = {dir, sr(0, '0)};
        dir = {dir, lr(511, 0, 0, 511, 1, 2, 240, 15, 204)};
        dir = {dir, sr(0, '0)};

        foreach (dir[i]) begin
            if (dir[i].chk) begin
                send_item(dir[i].item);
                pending[pending.size() - 1] = dir[i].want;
            end else begin
                send_item(dir[i].item);
            end
            idle_gap();
        end

        // Hold the sender until every result of the directed part is back.
        start <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end

        // Random part: small triangles drained mostly, with stray steps and early reloads.
        for (int n = 0; n < 1700; ) begin
            it = make_load(($urandom_range(0, 30) == 0) ? 511 : $urandom_range(1, 6));
            send_item(it);
            n++;
            idle_gap();
            steps_left = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : 400;
            while (steps_left > 0 && part != 0 && n < 1700) begin
                send_item(make_step());
                n++;
                steps_left--;
                idle_gap();
            end
            if ($urandom_range(0, 4) == 0) begin
                send_item(make_step());
                n++;
            end
            if ($urandom_range(0, 49) == 0) begin
                start <= 1'b0;
                @(posedge i_clk);
                guard = 0;
                while (pending.size() != 0 && guard < 100000) begin
                    @(posedge i_clk);
                    guard++;
                end
            end
        end
        start <= 1'b0;

        guard = 0;
        while (pending.size() != 0) begin
            @(posedge i_clk);
            guard++;
            if (guard > 2000000) begin
                $display("flat_triangle_rasterizer test failed");
                $finish;
            end
        end
        repeat (400) @(posedge i_clk);

        $display("Covered %0d loads, %0d pixels and %0d end markers; %0d mismatches.",
                 loads_sent, pixels_seen, markers_seen, errors);
        if (errors == 0 && pending.size() == 0) begin
            $display("flat_triangle_rasterizer test passed");
        end else begin
            $display("flat_triangle_rasterizer test failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/ftr_pkg.sv
rtl/ftr_front.sv
rtl/ftr_div.sv
rtl/ftr_back.sv
rtl/flat_triangle_rasterizer.sv
sim/flat_triangle_rasterizer_tb.sv
